/* src/gri_pkg.sv */
// ----------------------------------------------------------------------------
// gri_pkg
// Types, codes and constants shared by the three-axis gyro rate integrator.
// ----------------------------------------------------------------------------
package gri_pkg;

    // field widths
    localparam int GRI_ANGLE_BITS = 48;
    localparam int GRI_AXES       = 3;
    localparam int GRI_AXIS_W     = 2;
    localparam int GRI_RATE_W     = 16;
    localparam int GRI_STAMP_W    = 32;
    localparam int GRI_GAIN_W     = 16;
    localparam int GRI_DB_W       = 15;
    localparam int GRI_ACT_W      = 2;

    // magnitude of cur + prev - 2 * offset
    localparam int GRI_MAG_W      = GRI_RATE_W + 1;

    // increment = |n| * gain * dt * 128 / 1000 = |n| * gain * dt * 16 / 125
    localparam int GRI_DIVISOR    = 125;
    localparam int GRI_PRE_SHIFT  = 4;
    localparam int GRI_QUOT_W     = 63;

    // signed width for the saturating accumulate
    localparam int GRI_SUM_W = ((GRI_ANGLE_BITS > GRI_QUOT_W) ? GRI_ANGLE_BITS : GRI_QUOT_W) + 2;

    // action codes
    localparam logic [GRI_ACT_W-1:0] ACT_INTEG = 2'd0;
    localparam logic [GRI_ACT_W-1:0] ACT_ZERO  = 2'd1;
    localparam logic [GRI_ACT_W-1:0] ACT_TIMER = 2'd2;

    // configuration register map
    localparam int GRI_CFG_IDX_W  = 3;
    localparam int GRI_CFG_DATA_W = 16;
    localparam logic [GRI_CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd0;
    localparam logic [GRI_CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd1;
    localparam logic [GRI_CFG_IDX_W-1:0] CFG_OFFSET_Z = 3'd2;
    localparam logic [GRI_CFG_IDX_W-1:0] CFG_DEADBAND = 3'd3;
    localparam logic [GRI_CFG_IDX_W-1:0] CFG_GAIN     = 3'd4;

    localparam logic [GRI_GAIN_W-1:0] GRI_GAIN_RESET = 16'd256;

    // input request
    typedef struct packed {
        logic [GRI_ACT_W-1:0]          action;
        logic signed [GRI_RATE_W-1:0]  rate_x;
        logic signed [GRI_RATE_W-1:0]  rate_y;
        logic signed [GRI_RATE_W-1:0]  rate_z;
        logic [GRI_STAMP_W-1:0]        stamp_ms;
    } t_in;

    // result request
    typedef struct packed {
        logic signed [GRI_ANGLE_BITS-1:0] angle_x;
        logic signed [GRI_ANGLE_BITS-1:0] angle_y;
        logic signed [GRI_ANGLE_BITS-1:0] angle_z;
    } t_out;

    // sequencer to multiply/divide unit
    typedef struct packed {
        logic                   start;
        logic [GRI_MAG_W-1:0]   mag;
        logic [GRI_GAIN_W-1:0]  gain;
        logic [GRI_STAMP_W-1:0] dt;
    } t_mdu_ctl;

    // multiply/divide unit to sequencer
    typedef struct packed {
        logic                  done;
        logic [GRI_QUOT_W-1:0] quot;
    } t_mdu_sts;

endpackage

/* src/gri_mdu.sv */
// ----------------------------------------------------------------------------
// gri_mdu
// Shared multiply and divide unit: floor(mag * gain * dt * 16 / 125) using
// one 33x16 multiplier in three steps and a radix-16 divider by 125.
// ----------------------------------------------------------------------------
module gri_mdu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gri_pkg::t_mdu_ctl   i_ctl,
    output gri_pkg::t_mdu_sts   o_sts
);
    import gri_pkg::*;

    localparam int A_W    = GRI_MAG_W + GRI_GAIN_W;
    localparam int H_W    = GRI_STAMP_W / 2;
    localparam int M_W    = A_W + H_W;
    localparam int P_W    = A_W + GRI_STAMP_W;
    localparam int DIGITS = (P_W + GRI_PRE_SHIFT + 3) / 4;
    localparam int D_W    = DIGITS * 4;
    localparam int R_W    = $clog2(GRI_DIVISOR);
    localparam int V_W    = R_W + 4;
    localparam int C_W    = $clog2(DIGITS);

    localparam logic [2:0] MS_IDLE = 3'd0;
    localparam logic [2:0] MS_MUL0 = 3'd1;
    localparam logic [2:0] MS_MUL1 = 3'd2;
    localparam logic [2:0] MS_MUL2 = 3'd3;
    localparam logic [2:0] MS_DIV  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [C_W-1:0]         r_cnt;
    logic                   r_done, n_done;
    logic [GRI_MAG_W-1:0]   r_mag;
    logic [GRI_GAIN_W-1:0]  r_gain;
    logic [GRI_STAMP_W-1:0] r_dt;
    logic [A_W-1:0]         r_a;
    logic [P_W-1:0]         r_prod;
    logic [D_W-1:0]         r_dvd;
    logic [R_W-1:0]         r_rem;
    logic [GRI_QUOT_W-1:0]  r_quot;

    logic [A_W-1:0]         w_mul_a;
    logic [H_W-1:0]         w_mul_b;
    logic [M_W-1:0]         w_mul;
    logic [P_W-1:0]         w_full;
    logic [V_W-1:0]         w_v;
    logic [3:0]             w_digit;
    logic [V_W-1:0]         w_rem;

    // quotient digit of a partial remainder below 16 * 125
    function automatic logic [3:0] f_digit(input logic [V_W-1:0] v);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 16; k++) begin
            if (v >= V_W'(k * GRI_DIVISOR)) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            MS_MUL0: begin
                w_mul_a = A_W'(r_mag);
                w_mul_b = r_gain;
            end
            MS_MUL1: begin
                w_mul_a = r_a;
                w_mul_b = r_dt[H_W-1:0];
            end
            default: begin
                w_mul_a = r_a;
                w_mul_b = r_dt[GRI_STAMP_W-1:H_W];
            end
        endcase
    end

    assign w_mul  = M_W'(w_mul_a) * M_W'(w_mul_b);
    assign w_full = r_prod + (P_W'(w_mul) << H_W);

    // one radix-16 division step
    assign w_v     = {r_rem, r_dvd[D_W-1 -: 4]};
    assign w_digit = f_digit(w_v);
    assign w_rem   = w_v - V_W'(w_digit) * V_W'(GRI_DIVISOR);

    // step sequencing
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            MS_IDLE: begin
                if (i_ctl.start) begin
                    n_state = MS_MUL0;
                end
            end
            MS_MUL0: n_state = MS_MUL1;
            MS_MUL1: n_state = MS_MUL2;
            MS_MUL2: n_state = MS_DIV;
            MS_DIV: begin
                if (r_cnt == C_W'(DIGITS - 1)) begin
                    n_state = MS_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_state = MS_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            MS_IDLE: begin
                if (i_ctl.start) begin
                    r_mag  <= i_ctl.mag;
                    r_gain <= i_ctl.gain;
                    r_dt   <= i_ctl.dt;
                end
            end
            MS_MUL0: r_a    <= w_mul[A_W-1:0];
            MS_MUL1: r_prod <= P_W'(w_mul);
            MS_MUL2: begin
                r_dvd  <= D_W'(w_full) << GRI_PRE_SHIFT;
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= '0;
            end
            MS_DIV: begin
                r_dvd  <= r_dvd << 4;
                r_rem  <= w_rem[R_W-1:0];
                r_quot <= {r_quot[GRI_QUOT_W-5:0], w_digit};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_sts.done = r_done;
    assign o_sts.quot = r_quot;

endmodule

/* src/gyro_rate_integrator_3axis_top.sv */
// ----------------------------------------------------------------------------
// gyro_rate_integrator_3axis_top
// Trapezoidal three-axis gyro angle integrator with saturating angles.
// ----------------------------------------------------------------------------
// A zero or timer request goes straight to the output state; an integrate
// request visits each axis in turn, skipping one inside the deadband and
// else waiting on the shared unit (3 multiply and 18 radix-16 divide steps).
// One request at a time; the input stalls until the result is registered.
// Reset is synchronous, active low: angles, samples and timer go to zero,
// gain to 1.0, offsets and deadband to zero.
module gyro_rate_integrator_3axis_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  gri_pkg::t_in                        i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output gri_pkg::t_out                       o_out_data,
    input  logic                                i_cfg_we,
    input  logic [gri_pkg::GRI_CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gri_pkg::GRI_CFG_DATA_W-1:0]  i_cfg_data
);
    import gri_pkg::*;

    localparam int A  = GRI_ANGLE_BITS;
    localparam int S  = GRI_SUM_W;
    localparam int RW = GRI_RATE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_AXIS = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [GRI_AXIS_W-1:0]    r_axis, n_axis;
    logic                     r_out_valid, n_out_valid;
    t_out                     r_out;

    logic signed [RW-1:0]     r_offset [GRI_AXES];
    logic [GRI_DB_W-1:0]      r_deadband;
    logic [GRI_GAIN_W-1:0]    r_gain;
    logic signed [A-1:0]      r_acc    [GRI_AXES];
    logic signed [RW-1:0]     r_prev   [GRI_AXES];
    logic signed [RW-1:0]     r_cur    [GRI_AXES];
    logic [GRI_STAMP_W-1:0]   r_prev_stamp;
    logic [GRI_STAMP_W-1:0]   r_dt;

    logic                     w_accept;
    logic                     w_last;
    logic                     w_skip;
    logic                     w_flow_end;
    logic signed [RW-1:0]     w_cur, w_prev, w_off;
    logic signed [RW:0]       w_dev;
    logic [RW:0]              w_adev;
    logic signed [RW+1:0]     w_n, w_n_neg;
    logic [GRI_MAG_W-1:0]     w_mag;
    logic signed [S-1:0]      w_acc_ext, w_m_ext, w_sum, w_hi, w_lo;
    logic signed [A-1:0]      w_acc_sat;
    t_mdu_ctl                 w_ctl;
    t_mdu_sts                 w_sts;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_last   = (r_axis == GRI_AXIS_W'(GRI_AXES - 1));

    // per-axis deviation, deadband and trapezoid sum
    assign w_cur   = r_cur[r_axis];
    assign w_prev  = r_prev[r_axis];
    assign w_off   = r_offset[r_axis];
    assign w_dev   = {w_cur[RW-1], w_cur} - {w_off[RW-1], w_off};
    assign w_adev  = w_dev[RW] ? (RW+1)'(-w_dev) : w_dev;
    assign w_skip  = (w_adev < (RW+1)'(r_deadband));
    assign w_n     = {{2{w_cur[RW-1]}}, w_cur} + {{2{w_prev[RW-1]}}, w_prev}
                   - {w_off[RW-1], w_off, 1'b0};
    assign w_n_neg = -w_n;
    assign w_mag   = w_n[RW+1] ? w_n_neg[GRI_MAG_W-1:0] : w_n[GRI_MAG_W-1:0];

    // shared multiply/divide unit
    assign w_ctl.start = (r_state == ST_AXIS) && !w_skip;
    assign w_ctl.mag   = w_mag;
    assign w_ctl.gain  = r_gain;
    assign w_ctl.dt    = r_dt;

    gri_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts)
    );

    // saturating accumulate, the sign of n sets the direction
    assign w_acc_ext = {{(S-A){r_acc[r_axis][A-1]}}, r_acc[r_axis]};
    assign w_m_ext   = {{(S-GRI_QUOT_W){1'b0}}, w_sts.quot};
    assign w_sum     = w_n[RW+1] ? (w_acc_ext - w_m_ext) : (w_acc_ext + w_m_ext);
    assign w_hi      = {{(S-A+1){1'b0}}, {(A-1){1'b1}}};
    assign w_lo      = ~w_hi;

    always_comb begin
        if (w_sum > w_hi) begin
            w_acc_sat = {1'b0, {(A-1){1'b1}}};
        end else if (w_sum < w_lo) begin
            w_acc_sat = {1'b1, {(A-1){1'b0}}};
        end else begin
            w_acc_sat = w_sum[A-1:0];
        end
    end

    assign w_flow_end = w_last && (((r_state == ST_AXIS) && w_skip)
                                || ((r_state == ST_WAIT) && w_sts.done));

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_axis = '0;
                    if (i_in_data.action == ACT_INTEG) begin
                        n_state = ST_AXIS;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_AXIS: begin
                if (w_skip) begin
                    if (w_last) begin
                        n_state = ST_OUT;
                    end else begin
                        n_axis = r_axis + 1'b1;
                    end
                end else begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_sts.done) begin
                    if (w_last) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_AXIS;
                        n_axis  = r_axis + 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control, configuration and integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_axis       <= '0;
            r_out_valid  <= 1'b0;
            r_deadband   <= '0;
            r_gain       <= GRI_GAIN_RESET;
            r_prev_stamp <= '0;
            for (int i = 0; i < GRI_AXES; i++) begin
                r_offset[i] <= '0;
                r_acc[i]    <= '0;
                r_prev[i]   <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;

            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OFFSET_X: r_offset[0] <= i_cfg_data;
                    CFG_OFFSET_Y: r_offset[1] <= i_cfg_data;
                    CFG_OFFSET_Z: r_offset[2] <= i_cfg_data;
                    CFG_DEADBAND: r_deadband  <= i_cfg_data[GRI_DB_W-1:0];
                    CFG_GAIN:     r_gain      <= i_cfg_data;
                    default: ;
                endcase
            end

            // action handling at request accept
            if (w_accept) begin
                case (i_in_data.action)
                    ACT_INTEG: r_prev_stamp <= i_in_data.stamp_ms;
                    ACT_ZERO: begin
                        for (int i = 0; i < GRI_AXES; i++) begin
                            r_acc[i] <= '0;
                        end
                    end
                    ACT_TIMER: r_prev_stamp <= i_in_data.stamp_ms;
                    default: ;
                endcase
            end

            // angle update when the shared unit finishes
            if ((r_state == ST_WAIT) && w_sts.done) begin
                r_acc[r_axis] <= w_acc_sat;
            end

            // samples are recorded once all axes are through
            if (w_flow_end) begin
                for (int i = 0; i < GRI_AXES; i++) begin
                    r_prev[i] <= r_cur[i];
                end
            end
        end
    end

    // request payload and result registers
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in_data.action == ACT_INTEG)) begin
            r_cur[0] <= i_in_data.rate_x;
            r_cur[1] <= i_in_data.rate_y;
            r_cur[2] <= i_in_data.rate_z;
            r_dt     <= i_in_data.stamp_ms - r_prev_stamp;
        end
        if ((r_state == ST_OUT) && (!r_out_valid || !i_out_stall)) begin
            r_out.angle_x <= r_acc[0];
            r_out.angle_y <= r_acc[1];
            r_out.angle_z <= r_acc[2];
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* src/gri_checker.sv */
// ----------------------------------------------------------------------------
// gri_checker
// Port-level checks for the gyro rate integrator, bound to the top level.
// ----------------------------------------------------------------------------
module gri_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  gri_pkg::t_in                        i_in_data,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  gri_pkg::t_out                       o_out_data
);
    import gri_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // one request at a time: busy right after accepting
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled after request accept");

    // a result appears only at the end of a busy period
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request in flight");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // zero and timer requests return to idle straight after the output state
    a_short_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_data.action == ACT_ZERO || i_in_data.action == ACT_TIMER)
            && !o_out_valid |=> ##1 !o_in_stall)
        else $error("zero or timer request took too long");

endmodule

bind gyro_rate_integrator_3axis_top gri_checker u_gri_checker (.*);
